// File: rtl/core/rlfe_pkg.sv
// Shared constants, types and request codes of the RGB linear fade engine.
package rlfe_pkg;

    localparam int CHANNELS     = 3;
    localparam int TIME_BITS    = 32;
    localparam int PORT_TIME_W  = 32;
    localparam int LEVEL_BITS   = 8;
    localparam int REQ_BITS     = 3;
    localparam int MODE_BITS    = 2;
    localparam int CH_IDX_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int BIT_CNT_BITS = $clog2(LEVEL_BITS);

    typedef logic [TIME_BITS-1:0]  time_t;
    typedef logic [LEVEL_BITS-1:0] level_t;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_START = 3'd0,
        REQ_STOP  = 3'd1,
        REQ_POLL  = 3'd2,
        REQ_SET   = 3'd3,
        REQ_ON    = 3'd4,
        REQ_OFF   = 3'd5
    } req_t;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_PWM  = 2'd0,
        MODE_HIGH = 2'd1,
        MODE_LOW  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOAD,
        ST_DOUBLE,
        ST_ADD,
        ST_STORE
    } state_t;

endpackage

// File: rtl/core/rgb_linear_fade_engine.sv
// Top level of the RGB linear fade engine with its serial scaling divider.
//
//   channel  direction  handshake         payload
//   s_       in         s_valid/s_ready   req_type, now_ms, fade_ms, target_ch0..2
//   m_       out        m_valid/m_ready   duty_ch0..2, drive_mode, fading
//
// Every request except an active poll gives its result in the cycle after the transfer.
// An active poll gives its result from the check state once the fade has run out,
// otherwise once the shared divider has scaled each channel in turn (load, then a double
// and an add state per quotient bit, then store); no new request is taken meanwhile.
// Reset is synchronous and clears all levels, the fade start and length, and the mode.
// A new request is taken while the previous result is being transferred, never earlier.
module rgb_linear_fade_engine (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [rlfe_pkg::REQ_BITS-1:0]          s_req_type,
    input  logic [rlfe_pkg::PORT_TIME_W-1:0]       s_now_ms,
    input  logic [rlfe_pkg::PORT_TIME_W-1:0]       s_fade_ms,
    input  logic [rlfe_pkg::LEVEL_BITS-1:0]        s_target_ch0,
    input  logic [rlfe_pkg::LEVEL_BITS-1:0]        s_target_ch1,
    input  logic [rlfe_pkg::LEVEL_BITS-1:0]        s_target_ch2,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [rlfe_pkg::LEVEL_BITS-1:0]        m_duty_ch0,
    output logic [rlfe_pkg::LEVEL_BITS-1:0]        m_duty_ch1,
    output logic [rlfe_pkg::LEVEL_BITS-1:0]        m_duty_ch2,
    output logic [rlfe_pkg::MODE_BITS-1:0]         m_drive_mode,
    output logic                                   m_fading
);
    import rlfe_pkg::*;

    state_t  state_reg, state_next;
    level_t  cur_reg   [CHANNELS], cur_next   [CHANNELS];
    level_t  start_reg [CHANNELS], start_next [CHANNELS];
    level_t  goal_reg  [CHANNELS], goal_next  [CHANNELS];
    time_t   t0_reg, t0_next;
    time_t   len_reg, len_next;
    logic    active_reg, active_next;
    mode_t   mode_reg, mode_next;
    logic    m_valid_reg, m_valid_next;

    time_t   elapsed_reg, elapsed_next;
    time_t   lme_reg, lme_next;
    time_t   rem_reg, rem_next;
    level_t  quo_reg, quo_next;
    level_t  dig_reg, dig_next;
    logic [BIT_CNT_BITS-1:0] bit_reg, bit_next;
    logic [CH_IDX_BITS-1:0]  ch_reg, ch_next;
    logic    diff_reg, diff_next;

    level_t  tgt [CHANNELS];
    level_t  s_lvl, g_lvl, lvl;
    logic    s_ge_g;
    logic    accept;
    logic [TIME_BITS+1:0] dbl_ext, dbl_sub;
    time_t   add_sub;
    logic    add_ge;

    assign tgt[0] = s_target_ch0;
    assign tgt[1] = s_target_ch1;
    assign tgt[2] = s_target_ch2;

    assign s_ready      = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept       = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_duty_ch0   = cur_reg[0];
    assign m_duty_ch1   = cur_reg[1];
    assign m_duty_ch2   = cur_reg[2];
    assign m_drive_mode = mode_reg;
    assign m_fading     = active_reg;

    assign s_lvl   = start_reg[ch_reg];
    assign g_lvl   = goal_reg[ch_reg];
    assign s_ge_g  = (s_lvl >= g_lvl);
    assign lvl     = s_ge_g ? (s_lvl - quo_reg) : (s_lvl + quo_reg);
    assign dbl_ext = {1'b0, rem_reg, 1'b0};
    assign dbl_sub = dbl_ext - {2'b00, len_reg};
    assign add_ge  = (rem_reg >= lme_reg);
    assign add_sub = rem_reg - lme_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            t0_reg      <= '0;
            len_reg     <= '0;
            active_reg  <= 1'b0;
            mode_reg    <= MODE_PWM;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                cur_reg[i]   <= '0;
                start_reg[i] <= '0;
                goal_reg[i]  <= '0;
            end
        end else begin
            state_reg   <= state_next;
            t0_reg      <= t0_next;
            len_reg     <= len_next;
            active_reg  <= active_next;
            mode_reg    <= mode_next;
            m_valid_reg <= m_valid_next;
            for (int i = 0; i < CHANNELS; i++) begin
                cur_reg[i]   <= cur_next[i];
                start_reg[i] <= start_next[i];
                goal_reg[i]  <= goal_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        elapsed_reg <= elapsed_next;
        lme_reg     <= lme_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        dig_reg     <= dig_next;
        bit_reg     <= bit_next;
        ch_reg      <= ch_next;
        diff_reg    <= diff_next;
    end

    always_comb begin
        state_next   = state_reg;
        t0_next      = t0_reg;
        len_next     = len_reg;
        active_next  = active_reg;
        mode_next    = mode_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cur_next     = cur_reg;
        start_next   = start_reg;
        goal_next    = goal_reg;
        elapsed_next = elapsed_reg;
        lme_next     = lme_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        dig_next     = dig_reg;
        bit_next     = bit_reg;
        ch_next      = ch_reg;
        diff_next    = diff_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_valid_next = 1'b1;
                    case (req_t'(s_req_type))
                        REQ_START: begin
                            for (int i = 0; i < CHANNELS; i++) begin
                                start_next[i] = cur_reg[i];
                                goal_next[i]  = tgt[i];
                            end
                            t0_next     = time_t'(s_now_ms);
                            len_next    = time_t'(s_fade_ms);
                            active_next = 1'b1;
                        end
                        REQ_STOP: begin
                            active_next = 1'b0;
                        end
                        REQ_POLL: begin
                            if (active_reg) begin
                                m_valid_next = 1'b0;
                                elapsed_next = time_t'(s_now_ms) - t0_reg;
                                state_next   = ST_CHECK;
                            end
                        end
                        REQ_SET: begin
                            for (int i = 0; i < CHANNELS; i++) begin
                                cur_next[i] = tgt[i];
                            end
                            mode_next = MODE_PWM;
                        end
                        REQ_ON: begin
                            mode_next = MODE_HIGH;
                        end
                        REQ_OFF: begin
                            mode_next = MODE_LOW;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CHECK: begin
                mode_next = MODE_PWM;
                diff_next = 1'b0;
                ch_next   = '0;
                lme_next  = len_reg - elapsed_reg;
                if (elapsed_reg >= len_reg) begin
                    cur_next     = goal_reg;
                    active_next  = 1'b0;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                dig_next   = s_ge_g ? (s_lvl - g_lvl) : (g_lvl - s_lvl);
                rem_next   = '0;
                quo_next   = '0;
                bit_next   = '0;
                state_next = ST_DOUBLE;
            end
            ST_DOUBLE: begin
                if (!dbl_sub[TIME_BITS+1]) begin
                    rem_next = dbl_sub[TIME_BITS-1:0];
                    quo_next = {quo_reg[LEVEL_BITS-2:0], 1'b1};
                end else begin
                    rem_next = dbl_ext[TIME_BITS-1:0];
                    quo_next = {quo_reg[LEVEL_BITS-2:0], 1'b0};
                end
                state_next = ST_ADD;
            end
            ST_ADD: begin
                if (dig_reg[LEVEL_BITS-1]) begin
                    if (add_ge) begin
                        rem_next = add_sub;
                        quo_next = quo_reg + level_t'(1);
                    end else begin
                        rem_next = rem_reg + elapsed_reg;
                    end
                end
                dig_next = {dig_reg[LEVEL_BITS-2:0], 1'b0};
                bit_next = bit_reg + 1'b1;
                if (bit_reg == BIT_CNT_BITS'(LEVEL_BITS - 1)) begin
                    state_next = ST_STORE;
                end else begin
                    state_next = ST_DOUBLE;
                end
            end
            ST_STORE: begin
                cur_next[ch_reg] = lvl;
                diff_next        = diff_reg || (lvl != g_lvl);
                if (ch_reg == CH_IDX_BITS'(CHANNELS - 1)) begin
                    active_next  = diff_reg || (lvl != g_lvl);
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/rlfe_checker.sv
// Port-level assertions for the RGB linear fade engine and their bind.
module rlfe_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic [rlfe_pkg::REQ_BITS-1:0]   s_req_type,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [rlfe_pkg::LEVEL_BITS-1:0] m_duty_ch0,
    input logic [rlfe_pkg::MODE_BITS-1:0]  m_drive_mode,
    input logic                            m_fading
);
    import rlfe_pkg::*;

    logic s_xfer;
    assign s_xfer = s_valid && s_ready;

    // A new request is taken only when the output slot is free or being emptied.
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && m_valid |-> m_ready)
        else $error("request taken while a result is still held");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_duty_ch0) && $stable(m_drive_mode))
        else $error("stalled result changed");

    a_all_on: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && (s_req_type == REQ_ON) |=> m_valid && (m_drive_mode == MODE_HIGH))
        else $error("all on did not force pins high");

    a_all_off: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && (s_req_type == REQ_OFF) |=> m_valid && (m_drive_mode == MODE_LOW))
        else $error("all off did not force pins low");

    a_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && (s_req_type == REQ_STOP) |=> m_valid && !m_fading)
        else $error("stop left the fade running");

endmodule

bind rgb_linear_fade_engine rlfe_checker u_rlfe_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_req_type   (s_req_type),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_duty_ch0   (m_duty_ch0),
    .m_drive_mode (m_drive_mode),
    .m_fading     (m_fading)
);

// File: test/fade_checker.sv
// Checker that predicts the fade engine's results and compares every result transfer.
`timescale 1ns / 100ps

module fade_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [rlfe_pkg::REQ_BITS-1:0]    s_req_type,
    input  logic [rlfe_pkg::PORT_TIME_W-1:0] s_now_ms,
    input  logic [rlfe_pkg::PORT_TIME_W-1:0] s_fade_ms,
    input  logic [rlfe_pkg::LEVEL_BITS-1:0]  s_target_ch0,
    input  logic [rlfe_pkg::LEVEL_BITS-1:0]  s_target_ch1,
    input  logic [rlfe_pkg::LEVEL_BITS-1:0]  s_target_ch2,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [rlfe_pkg::LEVEL_BITS-1:0]  m_duty_ch0,
    input  logic [rlfe_pkg::LEVEL_BITS-1:0]  m_duty_ch1,
    input  logic [rlfe_pkg::LEVEL_BITS-1:0]  m_duty_ch2,
    input  logic [rlfe_pkg::MODE_BITS-1:0]   m_drive_mode,
    input  logic                             m_fading,
    output int                               fail_count,
    output int                               outstanding,
    output int                               checked
);
    import rlfe_pkg::*;

    typedef struct packed {
        level_t duty0;
        level_t duty1;
        level_t duty2;
        mode_t  drive;
        logic   busy;
    } led_state_t;

    level_t     now_level  [CHANNELS];
    level_t     from_level [CHANNELS];
    level_t     goal_level [CHANNELS];
    time_t      fade_start;
    time_t      fade_span;
    logic       fade_on;
    mode_t      pin_drive;
    led_state_t led_states_due[$];

    function automatic level_t faded_level(level_t from, level_t goal, time_t elapsed,
                                           time_t length);
        logic [39:0] product;
        logic [39:0] step;
        level_t      gap;
        gap     = (from >= goal) ? from - goal : goal - from;
        product = {8'd0, elapsed} * {32'd0, gap};
        step    = product / {8'd0, length};
        return (from >= goal) ? from - step[7:0] : from + step[7:0];
    endfunction

    function automatic led_state_t led_view();
        return '{now_level[0], now_level[1], now_level[2], pin_drive, fade_on};
    endfunction

    task automatic clear_state();
        for (int i = 0; i < CHANNELS; i++) begin
            now_level[i]  = '0;
            from_level[i] = '0;
            goal_level[i] = '0;
        end
        fade_start  = '0;
        fade_span   = '0;
        fade_on     = 1'b0;
        pin_drive   = MODE_PWM;
    endtask

    task automatic take_request();
        level_t targets [CHANNELS];
        time_t  elapsed;
        targets = '{s_target_ch0, s_target_ch1, s_target_ch2};
        case (req_t'(s_req_type))
            REQ_START: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    from_level[i] = now_level[i];
                    goal_level[i] = targets[i];
                end
                fade_start  = s_now_ms;
                fade_span   = s_fade_ms;
                fade_on     = 1'b1;
            end
            REQ_STOP: begin
                fade_on = 1'b0;
            end
            REQ_POLL: begin
                if (fade_on) begin
                    fade_on   = 1'b0;
                    pin_drive = MODE_PWM;
                    elapsed   = s_now_ms - fade_start;
                    for (int i = 0; i < CHANNELS; i++) begin
                        if (elapsed >= fade_span) begin
                            now_level[i] = goal_level[i];
                        end else begin
                            now_level[i] = faded_level(from_level[i], goal_level[i], elapsed,
                                                       fade_span);
                            if (now_level[i] != goal_level[i]) fade_on = 1'b1;
                        end
                    end
                end
            end
            REQ_SET: begin
                for (int i = 0; i < CHANNELS; i++) now_level[i] = targets[i];
                pin_drive = MODE_PWM;
            end
            REQ_ON: begin
                pin_drive = MODE_HIGH;
            end
            REQ_OFF: begin
                pin_drive = MODE_LOW;
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_result();
        led_state_t want;
        if (led_states_due.size() == 0) begin
            $error("result transfer with no request waiting for it");
            fail_count++;
            return;
        end
        want = led_states_due.pop_front();
        checked++;
        if (m_duty_ch0 !== want.duty0) begin
            $error("duty_ch0: expected %0d, got %0d", want.duty0, m_duty_ch0);
            fail_count++;
        end
        if (m_duty_ch1 !== want.duty1) begin
            $error("duty_ch1: expected %0d, got %0d", want.duty1, m_duty_ch1);
            fail_count++;
        end
        if (m_duty_ch2 !== want.duty2) begin
            $error("duty_ch2: expected %0d, got %0d", want.duty2, m_duty_ch2);
            fail_count++;
        end
        if (m_drive_mode !== want.drive) begin
            $error("drive_mode: expected %0d, got %0d", want.drive, m_drive_mode);
            fail_count++;
        end
        if (m_fading !== want.busy) begin
            $error("fading: expected %0d, got %0d", want.busy, m_fading);
            fail_count++;
        end
    endtask

    // The result of an earlier request leaves before a request in the same cycle is predicted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_state();
            led_states_due.delete();
            fail_count = 0;
            checked    = 0;
        end else begin
            if (m_valid && m_ready) check_result();
            if (s_valid && s_ready) begin
                take_request();
                led_states_due.push_back(led_view());
            end
        end
        outstanding = led_states_due.size();
    end

endmodule

// File: test/testbench.sv
// Top of the fade engine testbench: clock, reset, request stimulus and the verdict.
`timescale 1ns / 100ps

module testbench;
    import rlfe_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_ITEMS = 400;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [REQ_BITS-1:0]    s_req_type;
    logic [PORT_TIME_W-1:0] s_now_ms;
    logic [PORT_TIME_W-1:0] s_fade_ms;
    logic [LEVEL_BITS-1:0]  s_target_ch0;
    logic [LEVEL_BITS-1:0]  s_target_ch1;
    logic [LEVEL_BITS-1:0]  s_target_ch2;
    logic                   m_valid;
    logic                   m_ready;
    logic [LEVEL_BITS-1:0]  m_duty_ch0;
    logic [LEVEL_BITS-1:0]  m_duty_ch1;
    logic [LEVEL_BITS-1:0]  m_duty_ch2;
    logic [MODE_BITS-1:0]   m_drive_mode;
    logic                   m_fading;

    int fail_count;
    int outstanding;
    int checked;
    int requests_sent;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;

    rgb_linear_fade_engine dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_now_ms    (s_now_ms),
        .s_fade_ms   (s_fade_ms),
        .s_target_ch0(s_target_ch0),
        .s_target_ch1(s_target_ch1),
        .s_target_ch2(s_target_ch2),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_duty_ch0  (m_duty_ch0),
        .m_duty_ch1  (m_duty_ch1),
        .m_duty_ch2  (m_duty_ch2),
        .m_drive_mode(m_drive_mode),
        .m_fading    (m_fading)
    );

    fade_checker checker_inst (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_now_ms    (s_now_ms),
        .s_fade_ms   (s_fade_ms),
        .s_target_ch0(s_target_ch0),
        .s_target_ch1(s_target_ch1),
        .s_target_ch2(s_target_ch2),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_duty_ch0  (m_duty_ch0),
        .m_duty_ch1  (m_duty_ch1),
        .m_duty_ch2  (m_duty_ch2),
        .m_drive_mode(m_drive_mode),
        .m_fading    (m_fading),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial begin
        aclk = 1'b0;
    end

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_req(input logic [REQ_BITS-1:0] req, input logic [31:0] now,
                            input logic [31:0] length, input logic [7:0] lvl0,
                            input logic [7:0] lvl1, input logic [7:0] lvl2);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_now_ms     <= now;
        s_fade_ms    <= length;
        s_target_ch0 <= lvl0;
        s_target_ch1 <= lvl1;
        s_target_ch2 <= lvl2;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests_sent++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic noise_req();
        send_req(REQ_BITS'($urandom_range(7)), $urandom, $urandom, $urandom, $urandom,
                 $urandom);
    endtask

    // A fade start then polls (a noise request now and then between), spread over and just past its length if short.
    task automatic fade_sequence();
        logic [31:0] t0;
        logic [31:0] length;
        logic [31:0] elapsed;
        int          pick;
        int          polls;
        t0   = $urandom;
        pick = $urandom_range(99);
        if (pick < 80) length = $urandom_range(1, 3000);
        else if (pick < 88) length = 0;
        else length = $urandom;
        send_req(REQ_START, t0, length, $urandom, $urandom, $urandom);
        polls = $urandom_range(1, 10);
        for (int i = 0; i < polls; i++) begin
            if ($urandom_range(99) < 12) noise_req();
            if (length <= 3000) elapsed = $urandom_range(0, length + length / 4 + 1);
            else elapsed = $urandom;
            send_req(REQ_POLL, t0 + elapsed, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic directed_reqs();
        send_req(REQ_POLL, 32'h0, 32'h0, 8'h00, 8'h00, 8'h00);
        send_req(REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'h00, 8'hAA);
        send_req(REQ_ON, 32'h0, 32'h0, 8'h00, 8'h00, 8'h00);
        send_req(REQ_OFF, 32'h0, 32'h0, 8'h00, 8'h00, 8'h00);
        send_req(REQ_POLL, 32'h1234, 32'h0, 8'h00, 8'h00, 8'h00);
        send_req(REQ_START, 32'hFFFF_FFF0, 32'd100, 8'h00, 8'hFF, 8'h55);
        send_req(REQ_POLL, 32'hFFFF_FFF0, 32'h0, 8'h00, 8'h00, 8'h00);
        send_req(REQ_POLL, 32'h0000_0010, 32'h0, 8'h00, 8'h00, 8'h00);
        send_req(REQ_ON, 32'h0, 32'h0, 8'h00, 8'h00, 8'h00);
        send_req(REQ_POLL, 32'h0000_0030, 32'h0, 8'h00, 8'h00, 8'h00);
        send_req(REQ_SET, 32'h0, 32'h0, 8'd10, 8'd20, 8'd30);
        send_req(REQ_POLL, 32'h0000_0040, 32'h0, 8'h00, 8'h00, 8'h00);
        send_req(REQ_POLL, 32'h0000_0060, 32'h0, 8'h00, 8'h00, 8'h00);
        send_req(REQ_POLL, 32'h0000_0070, 32'h0, 8'h00, 8'h00, 8'h00);
        send_req(REQ_START, 32'd5, 32'd0, 8'd1, 8'd2, 8'd3);
        send_req(REQ_POLL, 32'd5, 32'h0, 8'h00, 8'h00, 8'h00);
        send_req(REQ_START, 32'h0, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
        send_req(REQ_POLL, 32'h8000_0000, 32'h0, 8'h00, 8'h00, 8'h00);
        send_req(REQ_STOP, 32'h0, 32'h0, 8'h00, 8'h00, 8'h00);
        send_req(REQ_POLL, 32'hFFFF_FFFE, 32'h0, 8'h00, 8'h00, 8'h00);
        send_req(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
        send_req(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
        send_req(REQ_SET, 32'h0, 32'h0, 8'd40, 8'd50, 8'd60);
        send_req(REQ_START, 32'd1000, 32'd1000, 8'd40, 8'd50, 8'd60);
        send_req(REQ_POLL, 32'd1001, 32'h0, 8'h00, 8'h00, 8'h00);
        send_req(REQ_START, 32'd2000, 32'd500, 8'd200, 8'd0, 8'd100);
        send_req(REQ_POLL, 32'd1999, 32'h0, 8'h00, 8'h00, 8'h00);
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_req_type     = '0;
        s_now_ms       = '0;
        s_fade_ms      = '0;
        s_target_ch0   = '0;
        s_target_ch1   = '0;
        s_target_ch2   = '0;
        m_ready        = 1'b0;
        cycle_count    = 0;
        requests_sent  = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        directed_reqs();
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; ) begin
                if ($urandom_range(99) < 75) begin
                    int start_count;
                    start_count = requests_sent;
                    fade_sequence();
                    n += requests_sent - start_count;
                end else begin
                    noise_req();
                    n++;
                end
            end
            wait_drained();
        end

        repeat (60) @(posedge aclk);
        $display("tb: %0d requests sent, %0d results checked in four handshake timing phases,",
                 requests_sent, checked);
        $display("tb: covering directed fade corners, time stamp wrap and random fades.");
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
